>>> rtl/mmnr_pkg.sv
package mmnr_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_LISTEN_CHANNEL   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCENT_THRESHOLD = 1'd1;

    localparam logic [3:0] LISTEN_CHANNEL_RESET   = 4'd0;
    localparam logic [6:0] ACCENT_THRESHOLD_RESET = 7'd100;

    localparam logic [7:0] BYTE_CLOCK = 8'hF8;
    localparam logic [7:0] BYTE_START = 8'hFA;
    localparam logic [7:0] BYTE_STOP  = 8'hFC;

    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_SYSTEM   = 4'hF;

    localparam logic [7:0] NOTE_BASE = 8'h19;
    localparam logic [7:0] NO_NOTE   = 8'hFF;

    localparam logic [2:0] EV_NOTE_ON  = 3'd0;
    localparam logic [2:0] EV_NOTE_OFF = 3'd1;
    localparam logic [2:0] EV_START    = 3'd2;
    localparam logic [2:0] EV_STOP     = 3'd3;
    localparam logic [2:0] EV_CLOCK    = 3'd4;

    typedef enum logic [2:0] {
        CMD_CLOCK,
        CMD_START,
        CMD_STOP,
        CMD_NOTE_ON,
        CMD_RELEASE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] note;
        logic       accent;
    } t_cmd;

    function automatic logic [7:0] note_to_code(input logic [7:0] note);
        logic [7:0] code;
        code = (note == 8'd0) ? 8'd0 : note - NOTE_BASE;
        return code;
    endfunction

endpackage

>>> rtl/mmnr_if.sv
interface mmnr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface mmnr_evt_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] note_code;
    logic       slide;
    logic       accent;

    modport source (output valid, output event_kind, output note_code, output slide,
                    output accent, input ready);
    modport sink (input valid, input event_kind, input note_code, input slide,
                  input accent, output ready);
endinterface

interface mmnr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mmnr_pkg::CFG_INDEX_W-1:0]    index;
    logic [mmnr_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/mmnr_front.sv
module mmnr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mmnr_rx_if.sink           i_rx,
    mmnr_cfg_if.sink          i_cfg,
    input  logic              i_q_full,
    output logic              o_q_push,
    output mmnr_pkg::t_cmd    o_q_cmd
);

    typedef enum logic [1:0] {
        RK_IGNORE,
        RK_NOTE_ON,
        RK_NOTE_OFF,
        RK_OTHER
    } t_run_kind;

    t_run_kind  r_kind, n_kind;
    logic       r_want_vel, n_want_vel;
    logic [7:0] r_pending, n_pending;
    logic [3:0] r_channel;
    logic [6:0] r_threshold;

    logic       accept;
    logic [7:0] b;
    logic [3:0] hi;
    logic [3:0] lo;

    assign i_rx.ready  = i_rst_n && !i_q_full;
    assign i_cfg.ready = i_rst_n;
    assign accept      = i_rx.valid && i_rx.ready;
    assign b           = i_rx.rx_byte;
    assign hi          = b[7:4];
    assign lo          = b[3:0];

    always_comb begin
        n_kind         = r_kind;
        n_want_vel     = r_want_vel;
        n_pending      = r_pending;
        o_q_push       = 1'b0;
        o_q_cmd.kind   = mmnr_pkg::CMD_CLOCK;
        o_q_cmd.note   = r_pending;
        o_q_cmd.accent = 1'b0;
        if (accept) begin
            if (b == mmnr_pkg::BYTE_CLOCK) begin
                o_q_push = 1'b1;
            end else if (b[7]) begin
                n_want_vel = 1'b0;
                if (hi == mmnr_pkg::NIB_SYSTEM || lo == r_channel) begin
                    case (hi)
                        mmnr_pkg::NIB_NOTE_ON:  n_kind = RK_NOTE_ON;
                        mmnr_pkg::NIB_NOTE_OFF: n_kind = RK_NOTE_OFF;
                        default:                n_kind = RK_OTHER;
                    endcase
                    if (b == mmnr_pkg::BYTE_START) begin
                        o_q_push     = 1'b1;
                        o_q_cmd.kind = mmnr_pkg::CMD_START;
                    end else if (b == mmnr_pkg::BYTE_STOP) begin
                        o_q_push     = 1'b1;
                        o_q_cmd.kind = mmnr_pkg::CMD_STOP;
                    end
                end else begin
                    n_kind = RK_IGNORE;
                end
            end else if (r_kind inside {RK_NOTE_ON, RK_NOTE_OFF}) begin
                if (!r_want_vel) begin
                    n_pending  = b;
                    n_want_vel = 1'b1;
                end else begin
                    n_want_vel = 1'b0;
                    o_q_push   = 1'b1;
                    // A zero velocity on a nonzero note releases it.
                    if (r_kind == RK_NOTE_OFF || (b == 8'd0 && r_pending != 8'd0)) begin
                        o_q_cmd.kind = mmnr_pkg::CMD_RELEASE;
                    end else begin
                        o_q_cmd.kind   = mmnr_pkg::CMD_NOTE_ON;
                        o_q_cmd.accent = b[6:0] > r_threshold;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= RK_IGNORE;
            r_want_vel <= 1'b0;
            r_pending  <= 8'd0;
        end else begin
            r_kind     <= n_kind;
            r_want_vel <= n_want_vel;
            r_pending  <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel   <= mmnr_pkg::LISTEN_CHANNEL_RESET;
            r_threshold <= mmnr_pkg::ACCENT_THRESHOLD_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                mmnr_pkg::CFG_LISTEN_CHANNEL:   r_channel   <= i_cfg.data[3:0];
                mmnr_pkg::CFG_ACCENT_THRESHOLD: r_threshold <= i_cfg.data[6:0];
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/mmnr_queue.sv
module mmnr_queue #(
    parameter int Depth = mmnr_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mmnr_pkg::t_cmd    i_push_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_head_valid,
    output mmnr_pkg::t_cmd    o_head
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    mmnr_pkg::t_cmd r_mem [Depth];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_count, n_count;
    logic            push_ok;
    logic            pop_ok;

    assign o_full       = r_count == CntW'(Depth);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_mem[r_rd];
    assign push_ok      = i_push && !o_full;
    assign pop_ok       = i_pop && o_head_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push_ok) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

>>> rtl/mmnr_back.sv
module mmnr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  mmnr_pkg::t_cmd    i_head,
    output logic              o_pop,
    mmnr_evt_if.source        o_evt
);

    logic       r_valid, n_valid;
    logic [7:0] r_sounding, n_sounding;
    logic [2:0] r_kind, n_kind;
    logic [7:0] r_code, n_code;
    logic       r_slide, n_slide;
    logic       r_accent, n_accent;
    logic       take;

    assign take             = !r_valid || o_evt.ready;
    assign o_pop            = i_head_valid && take;
    assign o_evt.valid      = r_valid;
    assign o_evt.event_kind = r_kind;
    assign o_evt.note_code  = r_code;
    assign o_evt.slide      = r_slide;
    assign o_evt.accent     = r_accent;

    always_comb begin
        n_valid    = r_valid && !o_evt.ready;
        n_sounding = r_sounding;
        n_kind     = r_kind;
        n_code     = r_code;
        n_slide    = r_slide;
        n_accent   = r_accent;
        if (o_pop) begin
            n_code   = 8'd0;
            n_slide  = 1'b0;
            n_accent = 1'b0;
            case (i_head.kind)
                mmnr_pkg::CMD_CLOCK: begin
                    n_valid = 1'b1;
                    n_kind  = mmnr_pkg::EV_CLOCK;
                end
                mmnr_pkg::CMD_START: begin
                    n_valid = 1'b1;
                    n_kind  = mmnr_pkg::EV_START;
                end
                mmnr_pkg::CMD_STOP: begin
                    n_valid = 1'b1;
                    n_kind  = mmnr_pkg::EV_STOP;
                end
                mmnr_pkg::CMD_NOTE_ON: begin
                    n_valid    = 1'b1;
                    n_kind     = mmnr_pkg::EV_NOTE_ON;
                    n_code     = mmnr_pkg::note_to_code(i_head.note);
                    n_slide    = r_sounding != mmnr_pkg::NO_NOTE;
                    n_accent   = i_head.accent;
                    n_sounding = i_head.note;
                end
                mmnr_pkg::CMD_RELEASE: begin
                    // Only the sounding note can be released.
                    if (i_head.note == r_sounding) begin
                        n_valid    = 1'b1;
                        n_kind     = mmnr_pkg::EV_NOTE_OFF;
                        n_code     = mmnr_pkg::note_to_code(i_head.note);
                        n_sounding = mmnr_pkg::NO_NOTE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_sounding <= mmnr_pkg::NO_NOTE;
        end else begin
            r_valid    <= n_valid;
            r_sounding <= n_sounding;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_code   <= n_code;
        r_slide  <= n_slide;
        r_accent <= n_accent;
    end

endmodule

>>> rtl/midi_mono_note_receiver.sv
// An event reaches the output through the queue memory and then the output register.
// Throughput: one byte per cycle, sustained while the output side takes one event per cycle.
// A short queue between the byte parser and the note tracker absorbs output stalls.
// Reset is synchronous and active low; it restores the listen channel, accent threshold,
// running status and sounding note, and empties the queue and the output register.
module midi_mono_note_receiver #(
    parameter int QueueDepth = mmnr_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mmnr_rx_if.sink      i_rx,
    mmnr_cfg_if.sink     i_cfg,
    mmnr_evt_if.source   o_evt
);

    logic           q_push;
    mmnr_pkg::t_cmd q_push_cmd;
    logic           q_full;
    logic           q_pop;
    logic           q_head_valid;
    mmnr_pkg::t_cmd q_head;

    mmnr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_push_cmd)
    );

    mmnr_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_cmd   (q_push_cmd),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    mmnr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_evt        (o_evt)
    );

endmodule

>>> bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mmnr_pkg::*;

    typedef enum logic [1:0] {
        RUN_IGNORE,
        RUN_NOTE_ON,
        RUN_NOTE_OFF,
        RUN_OTHER
    } run_status_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] code;
        logic       slide;
        logic       accent;
    } midi_event_t;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic        given;
        logic        fires;
        midi_event_t ev;
    } stim_row_t;

    localparam midi_event_t NO_EVENT    = '0;
    localparam midi_event_t CLOCK_EVENT = '{EV_CLOCK, 8'h00, 1'b0, 1'b0};
    localparam midi_event_t START_EVENT = '{EV_START, 8'h00, 1'b0, 1'b0};
    localparam midi_event_t STOP_EVENT  = '{EV_STOP, 8'h00, 1'b0, 1'b0};
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int LIVE_PER_PHASE = 340;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mmnr_rx_if  rx ();
    mmnr_cfg_if cfg ();
    mmnr_evt_if evt ();

    midi_mono_note_receiver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx),
        .i_cfg   (cfg),
        .o_evt   (evt)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [3:0]  trk_channel;
    logic [6:0]  trk_threshold;
    run_status_t trk_status;
    logic        trk_want_vel;
    logic [7:0]  trk_held_note;
    logic [7:0]  trk_sounding;

    midi_event_t expected_events [$];
    stim_row_t   byte_plan [$];
    midi_event_t head_event;
    int          mismatch_count = 0;
    bit          calm = 1'b0;
    bit          hold_request = 1'b0;

    stim_row_t directed_rows [27] = '{
        '{8'hF8, 1'b1, 1'b1, CLOCK_EVENT},
        '{8'hFA, 1'b1, 1'b1, START_EVENT},
        '{8'hFC, 1'b1, 1'b1, STOP_EVENT},
        '{8'h90, 1'b1, 1'b0, NO_EVENT},
        '{8'h3C, 1'b0, 1'b0, NO_EVENT},
        '{8'h7F, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, NO_EVENT},
        '{8'h7F, 1'b0, 1'b0, NO_EVENT},
        '{8'h65, 1'b0, 1'b0, NO_EVENT},
        '{8'h80, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, NO_EVENT},
        '{8'h40, 1'b0, 1'b0, NO_EVENT},
        '{8'h7F, 1'b0, 1'b0, NO_EVENT},
        '{8'hF8, 1'b1, 1'b1, CLOCK_EVENT},
        '{8'h00, 1'b0, 1'b0, NO_EVENT},
        '{8'h90, 1'b0, 1'b0, NO_EVENT},
        '{8'h05, 1'b0, 1'b0, NO_EVENT},
        '{8'hFE, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, NO_EVENT},
        '{8'h91, 1'b1, 1'b0, NO_EVENT},
        '{8'h05, 1'b1, 1'b0, NO_EVENT},
        '{8'h90, 1'b0, 1'b0, NO_EVENT},
        '{8'h05, 1'b0, 1'b0, NO_EVENT},
        '{8'h64, 1'b0, 1'b0, NO_EVENT},
        '{8'h05, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, NO_EVENT}
    };

    function automatic logic [7:0] note_code_of(input logic [7:0] note);
        if (note == 8'd0) begin
            return 8'd0;
        end
        return note - NOTE_BASE;
    endfunction

    function automatic void parse_midi_byte(input logic [7:0] b, output bit fires,
                                            output midi_event_t ev);
        logic [7:0] note;
        fires = 1'b0;
        ev = NO_EVENT;
        if (b == BYTE_CLOCK) begin
            fires = 1'b1;
            ev = CLOCK_EVENT;
        end else if (b[7]) begin
            trk_want_vel = 1'b0;
            if (b[7:4] == NIB_SYSTEM || b[3:0] == trk_channel) begin
                if (b[7:4] == NIB_NOTE_ON) begin
                    trk_status = RUN_NOTE_ON;
                end else if (b[7:4] == NIB_NOTE_OFF) begin
                    trk_status = RUN_NOTE_OFF;
                end else begin
                    trk_status = RUN_OTHER;
                end
                if (b == BYTE_START) begin
                    fires = 1'b1;
                    ev = START_EVENT;
                end else if (b == BYTE_STOP) begin
                    fires = 1'b1;
                    ev = STOP_EVENT;
                end
            end else begin
                trk_status = RUN_IGNORE;
            end
        end else if (trk_status == RUN_NOTE_ON || trk_status == RUN_NOTE_OFF) begin
            if (!trk_want_vel) begin
                trk_held_note = b;
                trk_want_vel = 1'b1;
            end else begin
                trk_want_vel = 1'b0;
                note = trk_held_note;
                if (trk_status == RUN_NOTE_OFF || (b == 8'd0 && note != 8'd0)) begin
                    if (note == trk_sounding) begin
                        trk_sounding = NO_NOTE;
                        fires = 1'b1;
                        ev.kind = EV_NOTE_OFF;
                        ev.code = note_code_of(note);
                    end
                end else begin
                    fires = 1'b1;
                    ev.kind = EV_NOTE_ON;
                    ev.code = note_code_of(note);
                    ev.slide = (trk_sounding != NO_NOTE);
                    ev.accent = (b[6:0] > trk_threshold);
                    trk_sounding = note;
                end
            end
        end
    endfunction

    function automatic void plan_byte(input logic [7:0] b);
        byte_plan.push_back('{b, 1'b0, 1'b0, NO_EVENT});
    endfunction

    function automatic logic [7:0] pick_note();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'h18;
            2: return 8'h19;
            3: return 8'h3C;
            4: return 8'h7E;
            5: return 8'h7F;
            default: return 8'($urandom_range(0, 127));
        endcase
    endfunction

    // Mostly well-formed note messages on the listen channel, with clocks,
    // transport bytes, foreign traffic, broken messages and raw noise mixed in.
    function automatic int plan_message();
        int         sel;
        int         live;
        logic [7:0] vel;
        logic [3:0] nib;
        logic [3:0] other_ch;
        sel = $urandom_range(0, 99);
        live = 0;
        if (sel < 55) begin
            if ($urandom_range(0, 3) != 0) begin
                nib = ($urandom_range(0, 3) != 0) ? NIB_NOTE_ON : NIB_NOTE_OFF;
                plan_byte({nib, trk_channel});
                live++;
            end
            repeat ($urandom_range(1, 3)) begin
                plan_byte(pick_note());
                if ($urandom_range(0, 9) == 0) begin
                    plan_byte(BYTE_CLOCK);
                    live++;
                end
                case ($urandom_range(0, 5))
                    0: vel = 8'h00;
                    1: vel = {1'b0, trk_threshold};
                    2: begin
                        vel = {1'b0, trk_threshold} + 8'd1;
                        if (vel[7]) begin
                            vel = 8'h7F;
                        end
                    end
                    3: vel = 8'h7F;
                    default: vel = 8'($urandom_range(0, 127));
                endcase
                plan_byte(vel);
                live += 2;
            end
        end else if (sel < 65) begin
            plan_byte(BYTE_CLOCK);
            live++;
        end else if (sel < 70) begin
            plan_byte(($urandom_range(0, 1) != 0) ? BYTE_START : BYTE_STOP);
            live++;
        end else if (sel < 78) begin
            nib = 4'($urandom_range(8, 14));
            other_ch = trk_channel ^ 4'($urandom_range(1, 15));
            plan_byte({nib, other_ch});
            repeat ($urandom_range(0, 2)) plan_byte(8'($urandom_range(0, 127)));
        end else if (sel < 86) begin
            if ($urandom_range(0, 1) != 0) begin
                nib = 4'($urandom_range(10, 14));
                plan_byte({nib, trk_channel});
            end else begin
                plan_byte(8'($urandom_range(240, 255)));
            end
            repeat ($urandom_range(0, 2)) plan_byte(8'($urandom_range(0, 127)));
            live++;
        end else if (sel < 94) begin
            plan_byte({NIB_NOTE_ON, trk_channel});
            plan_byte(pick_note());
            plan_byte(8'($urandom_range(128, 255)));
            live += 3;
        end else begin
            plan_byte(8'($urandom_range(0, 255)));
        end
        return live;
    endfunction

    // Leaves valid high after the word is taken unless an idle burst follows,
    // so back-to-back words keep valid asserted.
    task automatic send_byte(input stim_row_t row);
        bit          fires;
        midi_event_t ev;
        rx.valid <= 1'b1;
        rx.rx_byte <= row.rx_byte;
        @(posedge i_clk);
        while (!rx.ready) @(posedge i_clk);
        parse_midi_byte(row.rx_byte, fires, ev);
        if (row.given) begin
            fires = row.fires;
            ev = row.ev;
        end
        if (fires) begin
            expected_events.push_back(ev);
        end
        if (!calm && $urandom_range(0, 7) == 0) begin
            rx.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= data;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        if (idx == CFG_LISTEN_CHANNEL) begin
            trk_channel = data[3:0];
        end else begin
            trk_threshold = data[6:0];
        end
    endtask

    task automatic set_config(input logic [3:0] ch, input logic [6:0] thr);
        write_reg(CFG_LISTEN_CHANNEL, {4'h0, ch});
        write_reg(CFG_ACCENT_THRESHOLD, {1'b0, thr});
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        evt.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                evt.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                evt.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                evt.ready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && evt.valid && evt.ready) begin
            if (expected_events.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected event: kind %0d code %02h slide %0b accent %0b",
                             evt.event_kind, evt.note_code, evt.slide, evt.accent);
                end
                mismatch_count++;
            end else begin
                head_event = expected_events.pop_front();
                if (evt.event_kind !== head_event.kind || evt.note_code !== head_event.code ||
                    evt.slide !== head_event.slide || evt.accent !== head_event.accent) begin
                    if (mismatch_count < 10) begin
                        $display("event mismatch: expected kind %0d code %02h slide %0b %s%0b",
                                 head_event.kind, head_event.code, head_event.slide,
                                 "accent ", head_event.accent);
                        $display("                got      kind %0d code %02h slide %0b %s%0b",
                                 evt.event_kind, evt.note_code, evt.slide, "accent ",
                                 evt.accent);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((rx.valid && rx.ready) || (evt.valid && evt.ready) ||
                (cfg.valid && cfg.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int         live;
        logic [3:0] ch;
        logic [6:0] thr;
        trk_channel = LISTEN_CHANNEL_RESET;
        trk_threshold = ACCENT_THRESHOLD_RESET;
        trk_status = RUN_IGNORE;
        trk_want_vel = 1'b0;
        trk_held_note = 8'h00;
        trk_sounding = NO_NOTE;
        i_rst_n <= 1'b0;
        rx.valid <= 1'b0;
        rx.rx_byte <= 8'h00;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i]);
        end
        rx.valid <= 1'b0;

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    ch = 4'd15;
                    thr = 7'd127;
                end
                1: begin
                    ch = 4'd0;
                    thr = 7'd0;
                end
                3: begin
                    ch = 4'd9;
                    thr = 7'($urandom_range(0, 127));
                end
                default: begin
                    ch = 4'($urandom_range(0, 15));
                    thr = 7'($urandom_range(0, 127));
                end
            endcase
            wait_drained();
            set_config(ch, thr);
            if (phase == 1) begin
                hold_request = 1'b1;
            end
            if (phase == 4) begin
                calm = 1'b1;
            end
            live = 0;
            while (live < LIVE_PER_PHASE) begin
                live += plan_message();
                while (byte_plan.size() != 0) begin
                    send_byte(byte_plan.pop_front());
                end
            end
            rx.valid <= 1'b0;
        end

        wait_drained();
        if (mismatch_count == 0 && expected_events.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/mmnr_pkg.sv
rtl/mmnr_if.sv
rtl/mmnr_front.sv
rtl/mmnr_queue.sv
rtl/mmnr_back.sv
rtl/midi_mono_note_receiver.sv
bench/tb_top.sv
